[design/ffba_pkg.sv]
package ffba_pkg;

  // Heap geometry
  localparam int HEAP_BYTES  = 65536;
  localparam int CHUNK_BYTES = 4096;
  localparam int STORE_WORDS = HEAP_BYTES / 4;
  localparam int IDX_W       = $clog2(STORE_WORDS);
  // Byte address math carries headroom for sums of two heap-sized values
  localparam int AW          = $clog2(HEAP_BYTES) + 4;
  localparam int CHUNK_SZ    = ((CHUNK_BYTES + 7) / 8) * 8;
  localparam int MIN_BLOCK   = 16;
  localparam int CHUNK_FITS  = (16 + CHUNK_SZ <= HEAP_BYTES) ? 1 : 0;
  localparam int BRK_INIT    = (CHUNK_FITS != 0) ? 16 + CHUNK_SZ : 16;
  localparam int INIT_WORDS  = (CHUNK_FITS != 0) ? 5 : 3;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);

  typedef logic [AW-1:0] addr_t;

  localparam addr_t HEAP_LIM  = addr_t'(HEAP_BYTES);
  localparam addr_t CHUNK_A   = addr_t'(CHUNK_SZ);
  localparam addr_t MIN_A     = addr_t'(MIN_BLOCK);
  localparam addr_t BRK_RESET = addr_t'(BRK_INIT);

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_OOM  = 2'd2;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_ZERO  = 2'd2,
    CMD_SKIP  = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    addr_t     need;
    addr_t     addr;
  } cmd_t;

  typedef struct packed {
    logic  init_done;
    addr_t brk;
  } bk_stat_t;

  // Boundary tag: size with allocated flag in bit 0
  function automatic logic [31:0] tag(input addr_t size, input logic used);
    logic [31:0] t;
    t = 32'(size);
    t[2:0] = {2'b00, used};
    return t;
  endfunction

  function automatic addr_t tag_size(input logic [31:0] t);
    return {t[AW-1:3], 3'b000};
  endfunction

endpackage

[design/ffba_front.sv]
module ffba_front import ffba_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [15:0] request_size,
  input  logic [15:0] block_addr,
  output logic        cmd_valid,
  output cmd_t        cmd,
  input  logic        cmd_pop
);

  cmd_t              q [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;
  cmd_t              cls;
  addr_t             rounded;
  logic              push;

  // Classify the incoming transaction
  always_comb begin
    rounded  = addr_t'(request_size) + addr_t'(15);
    cls.need = {rounded[AW-1:3], 3'b000};
    if (cls.need < MIN_A) begin
      cls.need = MIN_A;
    end
    cls.addr = addr_t'(block_addr);
    if (action == 1'b0) begin
      cls.kind = (request_size == 16'd0) ? CMD_ZERO : CMD_ALLOC;
    end else begin
      cls.kind = (block_addr[2:0] == 3'd0 && block_addr >= 16'd16) ? CMD_FREE : CMD_SKIP;
    end
  end

  assign in_ready  = (count < (QPTR_W+1)'(QDEPTH));
  assign push      = in_valid && in_ready;
  assign cmd_valid = (count != '0);
  assign cmd       = q[rptr];

  // Command queue toward the back end
  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (cmd_pop) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + (QPTR_W+1)'(push) - (QPTR_W+1)'(cmd_pop);
    end
  end

endmodule

[design/ffba_back.sv]
module ffba_back import ffba_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  output logic        cmd_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [15:0] payload_addr,
  output bk_stat_t    stat
);

  typedef enum logic [12:0] {
    S_INIT      = 13'b0000000000001,
    S_IDLE      = 13'b0000000000010,
    S_WALK_RD   = 13'b0000000000100,
    S_WALK_CHK  = 13'b0000000001000,
    S_GROW      = 13'b0000000010000,
    S_WRITE     = 13'b0000000100000,
    S_MRG_P     = 13'b0000001000000,
    S_MRG_N     = 13'b0000010000000,
    S_MRG_CHK   = 13'b0000100000000,
    S_PUT       = 13'b0001000000000,
    S_FREE_RD   = 13'b0010000000000,
    S_FREE_CHK  = 13'b0100000000000,
    S_DONE      = 13'b1000000000000
  } state_t;

  state_t      state, state_next;
  state_t      cont, cont_next;
  addr_t       brk, brk_next;
  addr_t       bp, bp_next;
  addr_t       sz, sz_next;
  addr_t       need, need_next;
  logic        is_alloc, is_alloc_next;
  logic [1:0]  res_st, res_st_next;
  addr_t       res_addr, res_addr_next;
  logic [31:0] pt, pt_next;
  addr_t       wa [4];
  logic [31:0] wd [4];
  addr_t       wa_next [4];
  logic [31:0] wd_next [4];
  logic [1:0]  wlast, wlast_next;
  logic [1:0]  widx, widx_next;
  logic [2:0]  init_cnt;

  // Heap word store
  logic [31:0] mem [STORE_WORDS];
  logic [31:0] mem_q;
  logic        rd_ok;
  logic        rd_en;
  addr_t       raddr;
  logic        we;
  addr_t       waddr;
  logic [31:0] wdata;
  logic [31:0] rdata;

  always_ff @(posedge clk) begin
    if (we && waddr < HEAP_LIM) begin
      mem[waddr[IDX_W+1:2]] <= wdata;
    end
    if (rd_en) begin
      mem_q <= mem[raddr[IDX_W+1:2]];
      rd_ok <= (raddr < HEAP_LIM);
    end
  end

  assign rdata = rd_ok ? mem_q : 32'd0;

  // Reset image: prologue, first chunk and epilogue
  addr_t       init_a;
  logic [31:0] init_d;
  always_comb begin
    init_a = addr_t'(4);
    init_d = tag(addr_t'(8), 1'b1);
    unique case (init_cnt)
      3'd0: begin
        init_a = addr_t'(4);
        init_d = tag(addr_t'(8), 1'b1);
      end
      3'd1: begin
        init_a = addr_t'(8);
        init_d = tag(addr_t'(8), 1'b1);
      end
      3'd2: begin
        init_a = addr_t'(12);
        init_d = (CHUNK_FITS != 0) ? tag(CHUNK_A, 1'b0) : tag('0, 1'b1);
      end
      3'd3: begin
        init_a = BRK_RESET - addr_t'(8);
        init_d = tag(CHUNK_A, 1'b0);
      end
      default: begin
        init_a = BRK_RESET - addr_t'(4);
        init_d = tag('0, 1'b1);
      end
    endcase
  end

  // Walk, grow, merge and placement datapath
  logic [31:0] t;
  addr_t       ts;
  addr_t       ext;
  addr_t       nsize;
  addr_t       nbp;
  addr_t       psize;
  logic        pfree;
  logic        nfree;
  addr_t       mbp;
  addr_t       msz;
  addr_t       rem;

  always_comb begin
    state_next    = state;
    cont_next     = cont;
    brk_next      = brk;
    bp_next       = bp;
    sz_next       = sz;
    need_next     = need;
    is_alloc_next = is_alloc;
    res_st_next   = res_st;
    res_addr_next = res_addr;
    pt_next       = pt;
    wlast_next    = wlast;
    widx_next     = widx;
    for (int i = 0; i < 4; i++) begin
      wa_next[i] = wa[i];
      wd_next[i] = wd[i];
    end
    cmd_pop = 1'b0;
    rd_en   = 1'b0;
    raddr   = bp - addr_t'(4);
    we      = 1'b0;
    waddr   = wa[widx];
    wdata   = wd[widx];
    t       = rdata;
    ts      = tag_size(rdata);
    ext     = (need > CHUNK_A) ? need : CHUNK_A;
    psize   = tag_size(pt);
    nsize   = ts;
    nbp     = bp + sz;
    pfree   = !pt[0] && psize != '0 && bp >= addr_t'(16) && psize <= bp - addr_t'(16);
    nfree   = !t[0] && nsize != '0 && nbp + nsize <= brk;
    mbp     = pfree ? bp - psize : bp;
    msz     = sz + (pfree ? psize : '0) + (nfree ? nsize : '0);
    rem     = sz - need;

    unique case (state)
      S_INIT: begin
        we    = 1'b1;
        waddr = init_a;
        wdata = init_d;
        if (init_cnt == 3'(INIT_WORDS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop       = 1'b1;
          need_next     = cmd.need;
          bp_next       = cmd.addr;
          res_addr_next = '0;
          res_st_next   = ST_OK;
          is_alloc_next = 1'b0;
          unique case (cmd.kind)
            CMD_ALLOC: begin
              is_alloc_next = 1'b1;
              bp_next       = addr_t'(8);
              state_next    = S_WALK_RD;
            end
            CMD_FREE: state_next = S_FREE_RD;
            CMD_ZERO: begin
              res_st_next = ST_ZERO;
              state_next  = S_DONE;
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      // First fit: one header per visit
      S_WALK_RD: begin
        if (bp + addr_t'(4) > brk) begin
          state_next = S_GROW;
        end else begin
          rd_en      = 1'b1;
          raddr      = bp - addr_t'(4);
          state_next = S_WALK_CHK;
        end
      end
      S_WALK_CHK: begin
        if (ts == '0 || bp + ts > brk) begin
          state_next = S_GROW;
        end else if (!t[0] && ts >= need) begin
          sz_next    = ts;
          state_next = S_PUT;
        end else begin
          bp_next    = bp + ts;
          state_next = S_WALK_RD;
        end
      end
      S_GROW: begin
        if (brk + ext > HEAP_LIM) begin
          res_st_next = ST_OOM;
          state_next  = S_DONE;
        end else begin
          wa_next[0] = brk - addr_t'(4);
          wd_next[0] = tag(ext, 1'b0);
          wa_next[1] = brk + ext - addr_t'(8);
          wd_next[1] = tag(ext, 1'b0);
          wa_next[2] = brk + ext - addr_t'(4);
          wd_next[2] = tag('0, 1'b1);
          wlast_next = 2'd2;
          widx_next  = 2'd0;
          bp_next    = brk;
          sz_next    = ext;
          brk_next   = brk + ext;
          cont_next  = S_MRG_P;
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        we        = 1'b1;
        widx_next = widx + 2'd1;
        if (widx == wlast) begin
          state_next = cont;
        end
      end
      // Coalesce: read previous footer, then next header
      S_MRG_P: begin
        rd_en      = 1'b1;
        raddr      = bp - addr_t'(8);
        state_next = S_MRG_N;
      end
      S_MRG_N: begin
        pt_next    = rdata;
        rd_en      = 1'b1;
        raddr      = bp + sz - addr_t'(4);
        state_next = S_MRG_CHK;
      end
      S_MRG_CHK: begin
        if (pfree || nfree) begin
          wa_next[0] = mbp - addr_t'(4);
          wd_next[0] = tag(msz, 1'b0);
          wa_next[1] = mbp + msz - addr_t'(8);
          wd_next[1] = tag(msz, 1'b0);
          wlast_next = 2'd1;
          widx_next  = 2'd0;
          bp_next    = mbp;
          sz_next    = msz;
          cont_next  = is_alloc ? S_PUT : S_DONE;
          state_next = S_WRITE;
        end else begin
          state_next = is_alloc ? S_PUT : S_DONE;
        end
      end
      // Place the block, splitting off a big enough remainder
      S_PUT: begin
        res_addr_next = bp;
        widx_next     = 2'd0;
        cont_next     = S_DONE;
        state_next    = S_WRITE;
        if (rem >= MIN_A) begin
          wa_next[0] = bp - addr_t'(4);
          wd_next[0] = tag(need, 1'b1);
          wa_next[1] = bp + need - addr_t'(8);
          wd_next[1] = tag(need, 1'b1);
          wa_next[2] = bp + need - addr_t'(4);
          wd_next[2] = tag(rem, 1'b0);
          wa_next[3] = bp + sz - addr_t'(8);
          wd_next[3] = tag(rem, 1'b0);
          wlast_next = 2'd3;
        end else begin
          wa_next[0] = bp - addr_t'(4);
          wd_next[0] = tag(sz, 1'b1);
          wa_next[1] = bp + sz - addr_t'(8);
          wd_next[1] = tag(sz, 1'b1);
          wlast_next = 2'd1;
        end
      end
      S_FREE_RD: begin
        rd_en      = 1'b1;
        raddr      = bp - addr_t'(4);
        state_next = S_FREE_CHK;
      end
      S_FREE_CHK: begin
        if (t[0] && ts != '0 && bp + ts <= brk) begin
          wa_next[0] = bp - addr_t'(4);
          wd_next[0] = tag(ts, 1'b0);
          wa_next[1] = bp + ts - addr_t'(8);
          wd_next[1] = tag(ts, 1'b0);
          wlast_next = 2'd1;
          widx_next  = 2'd0;
          sz_next    = ts;
          cont_next  = S_MRG_P;
          state_next = S_WRITE;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      init_cnt <= '0;
      brk      <= BRK_RESET;
    end else begin
      state <= state_next;
      brk   <= brk_next;
      if (state == S_INIT) begin
        init_cnt <= init_cnt + 3'd1;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    cont     <= cont_next;
    bp       <= bp_next;
    sz       <= sz_next;
    need     <= need_next;
    is_alloc <= is_alloc_next;
    res_st   <= res_st_next;
    res_addr <= res_addr_next;
    pt       <= pt_next;
    wlast    <= wlast_next;
    widx     <= widx_next;
    for (int i = 0; i < 4; i++) begin
      wa[i] <= wa_next[i];
      wd[i] <= wd_next[i];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || out_ready)) begin
      status       <= res_st;
      payload_addr <= res_addr[15:0];
    end
  end

  assign stat.init_done = (state != S_INIT);
  assign stat.brk       = brk;

endmodule

[design/first_fit_boundary_tag_allocator_top.sv]
// Channel | Signals                                      | Direction
// --------+----------------------------------------------+----------
// input   | in_valid, in_ready, action, request_size,    | in
//         | block_addr                                   |
// output  | out_valid, out_ready, status, payload_addr   | out
//
// An allocate reads one header of the single-port heap store per block
// visited by the first-fit walk, plus dispatch, growing, merging, the tag
// writes and the result; a free reads the header and, for a used block,
// writes its tags and merges; a zero-size request goes straight to the
// result, which is registered. After reset the prologue, first chunk and
// epilogue tags are written; inputs queue up (two deep) meanwhile. A stalled
// output holds the back end in its final state; the front keeps queueing until the queue is full.
module first_fit_boundary_tag_allocator_top import ffba_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [15:0] request_size,
  input  logic [15:0] block_addr,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [15:0] payload_addr
);

  logic     cmd_valid;
  cmd_t     cmd;
  logic     cmd_pop;
  bk_stat_t stat;

  ffba_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .request_size (request_size),
    .block_addr   (block_addr),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop)
  );

  ffba_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .payload_addr (payload_addr),
    .stat         (stat)
  );

`ifndef SYNTHESIS
  // Heap break only grows
  a_brk_mono: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> stat.brk >= $past(stat.brk))
    else $error("heap break moved backward");

  // Heap break stays aligned and inside the heap
  a_brk_range: assert property (@(posedge clk) disable iff (rst)
    stat.brk[2:0] == 3'd0 && stat.brk <= HEAP_LIM)
    else $error("heap break out of range");

  // No command leaves the queue before the reset image is written
  a_no_pop_init: assert property (@(posedge clk) disable iff (rst)
    !stat.init_done |-> !cmd_pop)
    else $error("command taken during heap init");

  // Result codes stay within the defined set
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_ZERO || status == ST_OOM))
    else $error("undefined status code");
`endif

endmodule
